// ===== sv/apotr_pkg.sv =====
package apotr_pkg;

    // Binary angle width of the heading; the heading field is fixed at this width.
    localparam int ANGLE_BITS = 16;
    // Length of the arctangent table, and so the most CORDIC iterations.
    localparam int ATAN_COUNT = 24;
    // CORDIC start value: 1/K in Q30.
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        logic                    mode;
        logic signed [31:0]      forward;
        logic [30:0]             turn_radius;
        logic signed [15:0]      rotation;
        logic signed [31:0]      set_x;
        logic signed [31:0]      set_y;
        logic [ANGLE_BITS-1:0]   set_heading;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic [ANGLE_BITS-1:0]   heading;
        logic                    started;
        logic                    fresh;
        logic                    saturated;
    } t_out_item;

    // Request to the CORDIC unit.
    typedef struct packed {
        logic                    start;
        logic [ANGLE_BITS-1:0]   angle;
    } t_cordic_req;

    // Answer of the CORDIC unit, sine and cosine in Q30.
    typedef struct packed {
        logic                    done;
        logic signed [32:0]      sin_q30;
        logic signed [32:0]      cos_q30;
    } t_cordic_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORD0,
        S_CORD1,
        S_MULX,
        S_ADDX,
        S_MULY,
        S_ADDY,
        S_OUT
    } t_state;

    localparam logic MODE_MOTION = 1'b0;
    localparam logic MODE_SET    = 1'b1;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/arc_odometry_pose_tracker_core.sv =====
// Channel | Direction | Handshake                     | Beat
// --------+-----------+-------------------------------+---------------------------
// in      | input     | i_in_valid / o_in_stall       | t_in_item  on i_in_data
// out     | output    | o_out_valid / i_out_stall     | t_out_item on o_out_data
//
// Straight motion: one CORDIC pass, two multiplies, two saturating adds; the result
// register loads in S_OUT once it is free, and the next beat is taken back in S_IDLE.
// Arc motion runs two CORDIC passes. Pose set and ignored items go straight to S_OUT.
// Reset is synchronous, active low; the pose clears, fresh comes up set.
// A new beat is taken while a result waits under i_out_stall; its own result then holds.
module arc_odometry_pose_tracker_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  apotr_pkg::t_in_item    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output apotr_pkg::t_out_item   o_out_data
);
    import apotr_pkg::*;

    // sequencer
    t_state                  r_state, n_state;

    // pose state
    logic signed [31:0]      r_px, n_px;
    logic signed [31:0]      r_py, n_py;
    logic [ANGLE_BITS-1:0]   r_head, n_head;
    logic                    r_started, n_started;
    logic                    r_fresh, n_fresh;

    // captured motion beat
    logic signed [31:0]      r_fwd, n_fwd;
    logic [30:0]             r_rad, n_rad;
    logic signed [15:0]      r_rot, n_rot;
    logic                    r_straight, n_straight;

    // trig of old and new heading, product, clip flag
    logic signed [32:0]      r_s0, n_s0, r_c0, n_c0;
    logic signed [32:0]      r_s1, n_s1, r_c1, n_c1;
    logic signed [65:0]      r_prod, n_prod;
    logic                    r_sat, n_sat;

    // result register
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    t_cordic_req             cordic_req;
    t_cordic_rsp             cordic_rsp;

    logic                    in_beat;
    logic [ANGLE_BITS-1:0]   h1;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      rnd_sum;
    logic signed [35:0]      delta;
    logic signed [36:0]      delta_dir;
    logic signed [37:0]      acc;
    logic signed [31:0]      acc_clip;
    logic                    acc_of;
    logic                    neg_arc;

    apotr_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_rsp   (cordic_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_beat     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // heading after the arc, wraps
    assign h1 = r_head + ANGLE_BITS'(r_rot);

    // multiplier operands: straight uses forward * trig(h0),
    // arc uses radius * difference of trig between end points
    always_comb begin
        if (r_straight) begin
            mul_a = 33'(r_fwd);
            mul_b = (r_state == S_MULX) ? r_c0 : r_s0;
        end else begin
            mul_a = $signed({2'b00, r_rad});
            mul_b = (r_state == S_MULX) ? (r_s1 - r_s0) : (r_c0 - r_c1);
        end
    end

    // round half up out of Q30, flip for a right-hand arc, add and clip
    assign neg_arc   = !r_straight && (r_rot[15] || (r_rot == 16'sd0));
    assign rnd_sum   = r_prod + (66'sd1 <<< 29);
    assign delta     = rnd_sum[65:30];
    assign delta_dir = neg_arc ? -37'(delta) : 37'(delta);
    assign acc       = ((r_state == S_ADDX) ? 38'(r_px) : 38'(r_py)) + 38'(delta_dir);
    assign acc_of    = !((acc[37:31] == 7'h00) || (acc[37:31] == 7'h7F));
    assign acc_clip  = !acc_of ? acc[31:0] :
                       (acc[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    always_comb begin
        n_state     = r_state;
        n_px        = r_px;
        n_py        = r_py;
        n_head      = r_head;
        n_started   = r_started;
        n_fresh     = r_fresh;
        n_fwd       = r_fwd;
        n_rad       = r_rad;
        n_rot       = r_rot;
        n_straight  = r_straight;
        n_s0        = r_s0;
        n_c0        = r_c0;
        n_s1        = r_s1;
        n_c1        = r_c1;
        n_prod      = r_prod;
        n_sat       = r_sat;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        cordic_req.start = 1'b0;
        cordic_req.angle = r_head;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_sat   = 1'b0;
                    n_state = S_OUT;
                    if (i_in_data.mode == MODE_MOTION) begin
                        // motion before the first pose set is dropped
                        if (r_started) begin
                            n_fwd      = i_in_data.forward;
                            n_rad      = i_in_data.turn_radius;
                            n_rot      = i_in_data.rotation;
                            n_straight = (i_in_data.forward != 32'sd0);
                            cordic_req.start = 1'b1;
                            cordic_req.angle = r_head;
                            n_state    = S_CORD0;
                        end
                    end else if (r_fresh) begin
                        // first pose set anchors the map at the origin
                        if (!r_started) begin
                            n_px      = '0;
                            n_py      = '0;
                            n_head    = '0;
                            n_started = 1'b1;
                        end else begin
                            n_px   = i_in_data.set_x;
                            n_py   = i_in_data.set_y;
                            n_head = i_in_data.set_heading;
                        end
                        n_fresh = 1'b0;
                    end
                end
            end
            S_CORD0: begin
                if (cordic_rsp.done) begin
                    n_s0 = cordic_rsp.sin_q30;
                    n_c0 = cordic_rsp.cos_q30;
                    if (r_straight) begin
                        n_state = S_MULX;
                    end else begin
                        cordic_req.start = 1'b1;
                        cordic_req.angle = h1;
                        n_state = S_CORD1;
                    end
                end
            end
            S_CORD1: begin
                if (cordic_rsp.done) begin
                    n_s1    = cordic_rsp.sin_q30;
                    n_c1    = cordic_rsp.cos_q30;
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                n_prod  = mul_a * mul_b;
                n_state = S_ADDX;
            end
            S_ADDX: begin
                n_px    = acc_clip;
                n_sat   = r_sat | acc_of;
                n_state = S_MULY;
            end
            S_MULY: begin
                n_prod  = mul_a * mul_b;
                n_state = S_ADDY;
            end
            S_ADDY: begin
                n_py    = acc_clip;
                n_sat   = r_sat | acc_of;
                n_fresh = 1'b1;
                if (!r_straight) begin
                    n_head = h1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait for the result register to drain
                if (!r_out_valid || !i_out_stall) begin
                    n_out.pos_x     = r_px;
                    n_out.pos_y     = r_py;
                    n_out.heading   = r_head;
                    n_out.started   = r_started;
                    n_out.fresh     = r_fresh;
                    n_out.saturated = r_sat;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_px        <= '0;
            r_py        <= '0;
            r_head      <= '0;
            r_started   <= 1'b0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_px        <= n_px;
            r_py        <= n_py;
            r_head      <= n_head;
            r_started   <= n_started;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd      <= n_fwd;
        r_rad      <= n_rad;
        r_rot      <= n_rot;
        r_straight <= n_straight;
        r_s0       <= n_s0;
        r_c0       <= n_c0;
        r_s1       <= n_s1;
        r_c1       <= n_c1;
        r_prod     <= n_prod;
        r_sat      <= n_sat;
        r_out      <= n_out;
    end

endmodule

// ===== sv/apotr_cordic.sv =====
module apotr_cordic #(
    parameter int STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  apotr_pkg::t_cordic_req   i_req,
    output apotr_pkg::t_cordic_rsp   o_rsp
);
    import apotr_pkg::*;

    localparam int NSTEP  = (STEPS < ATAN_COUNT) ? STEPS : ATAN_COUNT;
    localparam int STEP_W = $clog2(NSTEP);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [STEP_W-1:0]       r_step, n_step;
    logic signed [32:0]      r_x, n_x;
    logic signed [32:0]      r_y, n_y;
    logic signed [31:0]      r_z, n_z;
    logic [1:0]              r_quad, n_quad;

    logic [31:0]             a32;
    logic signed [32:0]      sh_x, sh_y;
    logic signed [31:0]      at;

    assign a32  = 32'(i_req.angle) << (32 - ANGLE_BITS);
    assign sh_x = r_y >>> r_step;
    assign sh_y = r_x >>> r_step;
    assign at   = atan_q30(5'(r_step));

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_quad = r_quad;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_x    = GAIN_Q30;
            n_y    = '0;
            n_z    = $signed({2'b00, a32[29:0]});
            n_quad = a32[31:30];
        end else if (r_busy) begin
            // one micro-rotation per cycle
            if (r_z >= 0) begin
                n_x = r_x - sh_x;
                n_y = r_y + sh_y;
                n_z = r_z - at;
            end else begin
                n_x = r_x + sh_x;
                n_y = r_y - sh_y;
                n_z = r_z + at;
            end
            if (r_step == STEP_W'(NSTEP - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_quad <= n_quad;
    end

    // quadrant fold-back
    always_comb begin
        o_rsp.done = r_done;
        case (r_quad)
            2'd0: begin
                o_rsp.cos_q30 = r_x;
                o_rsp.sin_q30 = r_y;
            end
            2'd1: begin
                o_rsp.cos_q30 = -r_y;
                o_rsp.sin_q30 = r_x;
            end
            2'd2: begin
                o_rsp.cos_q30 = -r_x;
                o_rsp.sin_q30 = -r_y;
            end
            default: begin
                o_rsp.cos_q30 = r_y;
                o_rsp.sin_q30 = -r_x;
            end
        endcase
    end

endmodule

// ===== sv/apotr_checker.sv =====
module apotr_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  apotr_pkg::t_out_item   o_out_data
);
    import apotr_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed under stall");

    // one beat at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // before start the pose stays at reset
    a_origin_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.started |->
            o_out_data.pos_x == 32'sd0 && o_out_data.pos_y == 32'sd0 &&
            o_out_data.heading == '0 && !o_out_data.saturated)
        else $error("pose moved before first pose set");

    // clipping only comes from an applied motion, which leaves fresh set
    a_sat_needs_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |-> o_out_data.fresh && o_out_data.started)
        else $error("saturated flagged without applied motion");

endmodule

bind arc_odometry_pose_tracker_core apotr_checker u_apotr_checker (.*);
